FILE: src/lpf_pkg.sv
// Shared constants, codes and result type for the length-prefixed packet FIFO.
`default_nettype none
package lpf_pkg;

  localparam int RING_BYTES     = 1024;
  localparam int MAX_PACKET_LEN = 64;
  localparam int PTR_W          = $clog2(RING_BYTES);
  localparam int USED_W         = $clog2(RING_BYTES + 1);
  localparam int CMP_W          = (USED_W > 9) ? USED_W : 9;
  localparam int CNT_W          = 10;
  localparam int LEN_W          = 8;

  localparam logic [2:0] ST_WRITTEN  = 3'd0;
  localparam logic [2:0] ST_REJECTED = 3'd1;
  localparam logic [2:0] ST_DATA     = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_SKIPPED  = 3'd4;

  typedef struct packed {
    logic             load;
    logic [2:0]       status;
    logic [7:0]       rbyte;
    logic             last;
    logic [LEN_W-1:0] slen;
    logic [CNT_W-1:0] held;
  } lpf_res_t;

endpackage
`default_nettype wire

FILE: src/lpf_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none
module lpf_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: src/lpf_ctrl.sv
// Write/read sequencer: packet admission, commit, and ring readout.
`default_nettype none
module lpf_ctrl
  import lpf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_kind,
  input  wire logic [7:0]       in_data,
  input  wire logic [LEN_W-1:0] in_len,
  input  wire logic [LEN_W-1:0] in_limit,
  input  wire logic             slot_free,
  output lpf_res_t              res,
  output logic                  mem_we,
  output logic [PTR_W-1:0]      mem_waddr,
  output logic [7:0]            mem_wdata,
  output logic                  mem_re,
  output logic [PTR_W-1:0]      mem_raddr,
  input  wire logic [7:0]       mem_rdata
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WFIRST = 2'd1;
  localparam logic [1:0] S_RLEN   = 2'd2;
  localparam logic [1:0] S_RDATA  = 2'd3;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_FILL = 2'd1;
  localparam logic [1:0] MODE_DROP = 2'd2;

  logic [1:0]        st_r, st_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic [PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [PTR_W-1:0]  fill_r, fill_nxt;
  logic [PTR_W-1:0]  raddr_r, raddr_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [LEN_W-1:0]  btg_r, btg_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic              pend_r, pend_nxt;
  logic              plast_r, plast_nxt;
  logic [7:0]        data_r, data_nxt;
  logic [LEN_W-1:0]  flen_r, flen_nxt;
  logic [LEN_W-1:0]  limit_r, limit_nxt;
  logic [LEN_W-1:0]  slen_r, slen_nxt;

  logic              accept;
  logic              do_fill;
  logic [7:0]        fill_data;
  logic              load;
  logic              issue;
  logic [CMP_W-1:0]  room;
  logic [CMP_W-1:0]  need;
  logic [USED_W-1:0] dec;
  logic              reject;

  assign in_ready = (st_r == S_IDLE) && slot_free;
  assign accept   = in_valid && in_ready;
  assign load     = pend_r && slot_free;
  assign issue    = (st_r == S_RDATA) && (rem_r != '0) && (!pend_r || load);

  always_comb begin
    room   = CMP_W'(RING_BYTES) - CMP_W'(used_r);
    need   = CMP_W'(in_len) + CMP_W'(1);
    reject = (in_len == '0) || (in_len > LEN_W'(MAX_PACKET_LEN)) || (room <= need);
    dec    = USED_W'(mem_rdata) + USED_W'(1);
  end

  always_comb begin
    st_nxt    = st_r;
    mode_nxt  = mode_r;
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    fill_nxt  = fill_r;
    raddr_nxt = raddr_r;
    used_nxt  = used_r;
    count_nxt = count_r;
    btg_nxt   = btg_r;
    rem_nxt   = rem_r;
    pend_nxt  = pend_r;
    plast_nxt = plast_r;
    data_nxt  = data_r;
    flen_nxt  = flen_r;
    limit_nxt = limit_r;
    slen_nxt  = slen_r;
    res       = '0;
    mem_we    = 1'b0;
    mem_waddr = wptr_r;
    mem_wdata = in_len;
    mem_re    = 1'b0;
    mem_raddr = rptr_r;
    do_fill   = 1'b0;
    fill_data = in_data;

    case (st_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind) begin
            if (count_r == '0) begin
              res.load   = 1'b1;
              res.status = ST_EMPTY;
              res.last   = 1'b1;
              res.held   = count_r;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = rptr_r;
              limit_nxt = in_limit;
              st_nxt    = S_RLEN;
            end
          end else begin
            case (mode_r)
              MODE_DROP: begin
                btg_nxt = (btg_r == '0) ? '0 : btg_r - LEN_W'(1);
                if (btg_r <= LEN_W'(1)) begin
                  mode_nxt = MODE_IDLE;
                end
              end
              MODE_FILL: begin
                do_fill = 1'b1;
              end
              default: begin
                if (reject) begin
                  res.load   = 1'b1;
                  res.status = ST_REJECTED;
                  res.last   = 1'b1;
                  res.slen   = in_len;
                  res.held   = count_r;
                  if (in_len > LEN_W'(1)) begin
                    btg_nxt  = in_len - LEN_W'(1);
                    mode_nxt = MODE_DROP;
                  end
                end else begin
                  mem_we    = 1'b1;
                  mem_waddr = wptr_r;
                  mem_wdata = in_len;
                  fill_nxt  = wptr_r + PTR_W'(1);
                  btg_nxt   = in_len;
                  flen_nxt  = in_len;
                  data_nxt  = in_data;
                  mode_nxt  = MODE_FILL;
                  st_nxt    = S_WFIRST;
                end
              end
            endcase
          end
        end
      end
      S_WFIRST: begin
        if (slot_free) begin
          do_fill   = 1'b1;
          fill_data = data_r;
          st_nxt    = S_IDLE;
        end
      end
      S_RLEN: begin
        if (slot_free) begin
          count_nxt = count_r - CNT_W'(1);
          used_nxt  = (used_r >= dec) ? used_r - dec : '0;
          rptr_nxt  = rptr_r + PTR_W'(1) + PTR_W'(mem_rdata);
          if ((mem_rdata > limit_r) || (mem_rdata == '0) ||
              (mem_rdata > 8'(MAX_PACKET_LEN))) begin
            res.load   = 1'b1;
            res.status = ST_SKIPPED;
            res.last   = 1'b1;
            res.slen   = mem_rdata;
            res.held   = count_r - CNT_W'(1);
            st_nxt     = S_IDLE;
          end else begin
            rem_nxt   = mem_rdata;
            raddr_nxt = rptr_r + PTR_W'(1);
            slen_nxt  = mem_rdata;
            st_nxt    = S_RDATA;
          end
        end
      end
      S_RDATA: begin
        if (issue) begin
          mem_re    = 1'b1;
          mem_raddr = raddr_r;
          raddr_nxt = raddr_r + PTR_W'(1);
          rem_nxt   = rem_r - LEN_W'(1);
          plast_nxt = (rem_r == LEN_W'(1));
        end
        if (load) begin
          res.load   = 1'b1;
          res.status = ST_DATA;
          res.rbyte  = mem_rdata;
          res.last   = plast_r;
          res.slen   = slen_r;
          res.held   = count_r;
          if (plast_r) begin
            st_nxt = S_IDLE;
          end
        end
        pend_nxt = issue || (pend_r && !load);
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    if (do_fill) begin
      mem_we    = 1'b1;
      mem_waddr = fill_r;
      mem_wdata = fill_data;
      fill_nxt  = fill_r + PTR_W'(1);
      btg_nxt   = btg_r - LEN_W'(1);
      if (btg_r == LEN_W'(1)) begin
        wptr_nxt   = fill_r + PTR_W'(1);
        count_nxt  = count_r + CNT_W'(1);
        used_nxt   = used_r + USED_W'(flen_r) + USED_W'(1);
        mode_nxt   = MODE_IDLE;
        res.load   = 1'b1;
        res.status = ST_WRITTEN;
        res.last   = 1'b1;
        res.slen   = flen_r;
        res.held   = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      mode_r  <= MODE_IDLE;
      wptr_r  <= '0;
      rptr_r  <= '0;
      fill_r  <= '0;
      raddr_r <= '0;
      used_r  <= '0;
      count_r <= '0;
      btg_r   <= '0;
      rem_r   <= '0;
      pend_r  <= 1'b0;
      plast_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      mode_r  <= mode_nxt;
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      fill_r  <= fill_nxt;
      raddr_r <= raddr_nxt;
      used_r  <= used_nxt;
      count_r <= count_nxt;
      btg_r   <= btg_nxt;
      rem_r   <= rem_nxt;
      pend_r  <= pend_nxt;
      plast_r <= plast_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    flen_r  <= flen_nxt;
    limit_r <= limit_nxt;
    slen_r  <= slen_nxt;
  end

  a_pend_in_rdata: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> st_r == S_RDATA)
    else $error("read pending outside data readout");

  a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_FILL |-> btg_r != '0)
    else $error("fill mode with no bytes to go");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_W'(RING_BYTES))
    else $error("ring occupancy exceeds capacity");

  a_rlen_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_RLEN |-> count_r != '0)
    else $error("length fetch with no committed packet");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    res.load |-> slot_free)
    else $error("result loaded into an occupied output slot");

endmodule
`default_nettype wire

FILE: src/length_prefixed_packet_fifo.sv
// Top level of the length-prefixed packet FIFO: ring RAM, sequencer, output register.
//
// Input beats (in_*): in_tuser selects a write byte (0) or a read request (1).
// Write bytes carry the payload byte and the packet length; the first byte of
// a packet admits or rejects it, and the last byte commits it. A read request
// returns the oldest committed packet as a run of beats ending with out_tlast,
// or one beat with status empty or skipped (length zero or over a limit).
// Timing: the first byte of an accepted packet holds off the next beat while
// the length byte and the payload byte both go through the single RAM write
// port. A read fetches the length byte from the RAM, then streams one payload
// byte per cycle through the registered RAM read port while the receiver takes
// them; the next item is taken after the run's last beat is loaded.
// Results enter the output register in the cycle after the one that
// produces them. When the receiver stalls, the output register holds and the
// sequencer waits; no beat is lost. Reset empties the ring logically (pointers
// and counts clear); the RAM contents are not cleared, and no clearing pass runs.
`default_nettype none
module length_prefixed_packet_fifo
  import lpf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // data_byte[7:0], packet_len[15:8], read_limit[23:16]
  input  wire logic        in_tuser,   // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // read_byte[7:0], stored_len[15:8], packets_held[25:16]
  output logic [2:0]       out_tuser,  // status
  output logic             out_tlast
);

  lpf_res_t         res;
  logic             slot_free;
  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic             mem_re;
  logic [PTR_W-1:0] mem_raddr;
  logic [7:0]       mem_rdata;

  logic             vld_r, vld_nxt;
  logic [2:0]       status_r;
  logic [7:0]       rbyte_r;
  logic             last_r;
  logic [LEN_W-1:0] slen_r;
  logic [CNT_W-1:0] held_r;

  assign slot_free = !vld_r || out_tready;

  lpf_ram #(
    .DEPTH (RING_BYTES),
    .WIDTH (8)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser),
    .in_data   (in_tdata[7:0]),
    .in_len    (in_tdata[15:8]),
    .in_limit  (in_tdata[23:16]),
    .slot_free (slot_free),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  always_comb begin
    vld_nxt = vld_r;
    if (res.load) begin
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      status_r <= res.status;
      rbyte_r  <= res.rbyte;
      last_r   <= res.last;
      slen_r   <= res.slen;
      held_r   <= res.held;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tuser  = status_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {6'd0, held_r, slen_r, rbyte_r};

endmodule
`default_nettype wire

FILE: verif/length_prefixed_packet_fifo_checker.sv
// Beat checker for the length-prefixed packet FIFO: tracks the ring, predicts and compares results.
`default_nettype none
module length_prefixed_packet_fifo_checker
  import lpf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [23:0] in_tdata,
  input  wire logic        in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [31:0] out_tdata,
  input  wire logic [2:0]  out_tuser,
  input  wire logic        out_tlast,
  output int               errors,
  output int               pending
);

  typedef enum logic [1:0] {FILL_IDLE, FILL_ACTIVE, FILL_DROP} fill_mode_e;

  typedef struct packed {
    logic [2:0]       status;
    logic [7:0]       rbyte;
    logic             last;
    logic [LEN_W-1:0] slen;
    logic [CNT_W-1:0] held;
  } fifo_beat_t;

  bit [7:0]    ring [RING_BYTES];
  int unsigned head_ptr;
  int unsigned tail_ptr;
  int unsigned fill_ptr;
  int unsigned occupied;
  int unsigned held_count;
  int unsigned bytes_left;
  fill_mode_e  fill_mode;
  fifo_beat_t  expected_beats[$];

  function automatic int unsigned ring_advance(int unsigned p, int unsigned n);
    return (p + n) % RING_BYTES;
  endfunction

  function automatic void queue_beat(logic [2:0] st, logic [7:0] rb, logic lst,
                                     int unsigned len);
    fifo_beat_t b;
    b.status = st;
    b.rbyte  = rb;
    b.last   = lst;
    b.slen   = LEN_W'(len);
    b.held   = CNT_W'(held_count);
    expected_beats.push_back(b);
  endfunction

  function automatic void predict_write(logic [7:0] data, int unsigned len);
    int unsigned plen;
    if (fill_mode == FILL_DROP) begin
      if (bytes_left > 0) bytes_left--;
      if (bytes_left == 0) fill_mode = FILL_IDLE;
      return;
    end
    if (fill_mode == FILL_IDLE) begin
      if (len == 0 || len > MAX_PACKET_LEN || RING_BYTES - occupied <= len + 1) begin
        if (len > 1) begin
          bytes_left = len - 1;
          fill_mode  = FILL_DROP;
        end
        queue_beat(ST_REJECTED, 8'h00, 1'b1, len);
        return;
      end
      ring[head_ptr] = 8'(len);
      fill_ptr       = ring_advance(head_ptr, 1);
      bytes_left     = len;
      fill_mode      = FILL_ACTIVE;
    end
    ring[fill_ptr] = data;
    fill_ptr = ring_advance(fill_ptr, 1);
    if (bytes_left > 0) bytes_left--;
    if (bytes_left != 0) return;
    plen       = ring[head_ptr];
    head_ptr   = fill_ptr;
    held_count++;
    occupied   += plen + 1;
    fill_mode  = FILL_IDLE;
    queue_beat(ST_WRITTEN, 8'h00, 1'b1, plen);
  endfunction

  function automatic void predict_read(int unsigned limit);
    int unsigned len;
    int unsigned p;
    if (held_count == 0) begin
      queue_beat(ST_EMPTY, 8'h00, 1'b1, 0);
      return;
    end
    len      = ring[tail_ptr];
    p        = ring_advance(tail_ptr, 1);
    tail_ptr = ring_advance(p, len);
    held_count--;
    occupied = (occupied >= len + 1) ? occupied - (len + 1) : 0;
    if (len > limit || len == 0 || len > MAX_PACKET_LEN) begin
      queue_beat(ST_SKIPPED, 8'h00, 1'b1, len);
      return;
    end
    for (int unsigned i = 0; i < len; i++) begin
      queue_beat(ST_DATA, ring[p], (i + 1 == len), len);
      p = ring_advance(p, 1);
    end
  endfunction

  always @(posedge clk) begin
    fifo_beat_t got;
    fifo_beat_t want;
    if (!rst_n) begin
      head_ptr   = 0;
      tail_ptr   = 0;
      fill_ptr   = 0;
      occupied   = 0;
      held_count = 0;
      bytes_left = 0;
      fill_mode  = FILL_IDLE;
      expected_beats.delete();
      errors     = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status = out_tuser;
        got.rbyte  = out_tdata[7:0];
        got.last   = out_tlast;
        got.slen   = out_tdata[15:8];
        got.held   = out_tdata[25:16];
        if (expected_beats.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat: status=%0d byte=%02h last=%0d len=%0d held=%0d",
                   $time, got.status, got.rbyte, got.last, got.slen, got.held);
        end else begin
          want = expected_beats.pop_front();
          if (got.status !== want.status || got.rbyte !== want.rbyte ||
              got.last !== want.last || got.slen !== want.slen || got.held !== want.held) begin
            errors++;
            $display("%0t: beat mismatch: expected status=%0d byte=%02h last=%0d len=%0d held=%0d",
                     $time, want.status, want.rbyte, want.last, want.slen, want.held);
            $display("%0t:                got      status=%0d byte=%02h last=%0d len=%0d held=%0d",
                     $time, got.status, got.rbyte, got.last, got.slen, got.held);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser) predict_read(in_tdata[23:16]);
        else predict_write(in_tdata[7:0], in_tdata[15:8]);
      end
    end
    pending = expected_beats.size();
  end

endmodule
`default_nettype wire

FILE: verif/length_prefixed_packet_fifo_tb.sv
// Testbench top for the length-prefixed packet FIFO: clock, reset, stimulus and verdict.
`default_nettype none
module length_prefixed_packet_fifo_tb;
  import lpf_pkg::*;

  typedef enum bit {KIND_WRITE, KIND_READ} kind_e;

  localparam int RANDOM_ITEMS = 220;
  localparam int IDLE_LIMIT   = 2000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [23:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  int errors;
  int pending;
  int idle_cycles = 0;
  bit calm = 1'b0;
  int packets_sent = 0;
  int bad_sent     = 0;
  int reads_sent   = 0;
  int dropped      = 0;
  int drains       = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  length_prefixed_packet_fifo DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  length_prefixed_packet_fifo_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .errors     (errors),
    .pending    (pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [7:0] pick_limit();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(64, 255));
    return 8'($urandom_range(0, 63));
  endfunction

  task automatic send_beat(kind_e kind, logic [7:0] data, logic [7:0] len,
                           logic [7:0] limit);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {limit, len, data};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_read(logic [7:0] limit);
    reads_sent++;
    send_beat(KIND_READ, 8'($urandom), 8'($urandom), limit);
  endtask

  task automatic send_packet(int len, bit twist, bit read_inside);
    int at;
    logic [7:0] plen;
    at = read_inside ? $urandom_range(1, len) : -1;
    packets_sent++;
    for (int i = 0; i < len; i++) begin
      if (i == at) send_read(pick_limit());
      plen = (i > 0 && twist) ? 8'($urandom) : 8'(len);
      send_beat(KIND_WRITE, 8'($urandom), plen, 8'($urandom));
    end
  endtask

  task automatic send_bad(int len, bit read_inside);
    bad_sent++;
    send_beat(KIND_WRITE, 8'($urandom), 8'(len), 8'($urandom));
    for (int i = 1; i < len; i++) begin
      if (read_inside && i == 1) send_read(pick_limit());
      dropped++;
      send_beat(KIND_WRITE, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic drain();
    drains++;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 9) < 3) begin
        out_tready <= 1'b0;
        n = 1 + pick_gap();
        repeat (n - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog: no beat moved for %0d cycles, %0d results outstanding",
               $time, IDLE_LIMIT, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int counted;
    int r;
    int len;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_read(8'h00);
    send_read(8'hFF);
    send_beat(KIND_WRITE, 8'hA5, 8'd0, 8'h00);
    bad_sent++;
    send_beat(KIND_WRITE, 8'h00, 8'd1, 8'hFF);
    send_beat(KIND_WRITE, 8'hFF, 8'd1, 8'h00);
    send_beat(KIND_WRITE, 8'h11, 8'd3, 8'h00);
    send_beat(KIND_WRITE, 8'h22, 8'hFF, 8'hFF);
    send_beat(KIND_WRITE, 8'h33, 8'h00, 8'h00);
    packets_sent += 3;
    send_read(8'd0);
    send_read(8'd1);
    send_beat(KIND_WRITE, 8'h5A, 8'd2, 8'h00);
    send_read(8'd3);
    send_beat(KIND_WRITE, 8'hC3, 8'd7, 8'h00);
    packets_sent++;
    send_read(8'd2);
    send_read(8'hFF);
    send_bad(MAX_PACKET_LEN + 1, 1'b1);
    send_read(8'hFF);
    drain();

    calm = 1'b1;
    for (int i = 0; i < 15; i++) send_packet(MAX_PACKET_LEN, 1'b0, 1'b0);
    send_bad(48, 1'b0);
    send_packet(47, 1'b0, 1'b0);
    send_bad(1, 1'b0);
    calm = 1'b0;
    send_read(8'd63);
    for (int i = 0; i < 16; i++) send_read(8'hFF);
    drain();

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted % 30 == 0) calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 45) begin
        r = $urandom_range(0, 99);
        len = (r < 80) ? $urandom_range(1, 8) :
              (r < 95) ? $urandom_range(9, 63) : MAX_PACKET_LEN;
        send_packet(len, $urandom_range(0, 9) == 0, $urandom_range(0, 6) == 0);
        counted += len;
      end else if (r < 85) begin
        send_read(pick_limit());
        counted++;
      end else if (r < 95) begin
        r = $urandom_range(0, 9);
        len = (r < 3) ? 0 : (r < 9) ? $urandom_range(65, 80) : 255;
        send_bad(len, $urandom_range(0, 3) == 0);
        counted += (len > 1) ? len : 1;
      end else begin
        drain();
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Run covered %0d packets written, %0d rejected (%0d bytes dropped), %0d reads,",
             packets_sent, bad_sent, dropped, reads_sent);
    $display("a full ring, ring wrap, reads during fill and %0d drain pauses.", drains);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results still outstanding", errors, pending);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
